FILE: rtl/pdh_pkg.sv
// Shared types, constants and codes for the pot deadzone/hysteresis CC core.
// No dependencies; imported by every module of the block.
package pdh_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int SAMPLE_W     = 8;
    localparam int VAL_W        = 7;
    localparam int NUM_W        = 2 * SAMPLE_W;
    localparam int STORE_DEPTH  = (NUM_CHANNELS < (1 << CH_W)) ? NUM_CHANNELS : (1 << CH_W);
    localparam int IDX_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int STEP_W       = $clog2(NUM_W);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]          CC_STATUS  = 8'hB0;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'd255;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DZ_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DZ_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CC_BASE = 2'd3;

    localparam logic [7:0]       RST_DZ_LOW  = 8'd20;
    localparam logic [7:0]       RST_DZ_HIGH = 8'd240;
    localparam logic [VAL_W-1:0] RST_HYST    = 7'd4;
    localparam logic [VAL_W-1:0] RST_CC_BASE = 7'd16;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic                host_ready;
        logic                need_div;
        logic [SAMPLE_W-1:0] mapped;
        logic [NUM_W-1:0]    num;
        logic [SAMPLE_W-1:0] den;
    } t_work;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK
    } t_back_state;

endpackage

FILE: rtl/pdh_front.sv
// Front end: accepts samples, drops unknown channels, resolves deadzones
// and prepares the scaling division. Depends on pdh_pkg.
module pdh_front import pdh_pkg::*; (
    input  logic                i_push,
    input  logic                i_q_full,
    input  logic [CH_W-1:0]     i_channel,
    input  logic [SAMPLE_W-1:0] i_raw_sample,
    input  logic                i_host_ready,
    input  logic [SAMPLE_W-1:0] i_dz_low,
    input  logic [SAMPLE_W-1:0] i_dz_high,
    output logic                o_q_push,
    output t_work               o_word
);

    logic                ch_ok;
    logic [SAMPLE_W-1:0] span;
    logic [SAMPLE_W-1:0] den;

    assign ch_ok    = (32'(i_channel) < NUM_CHANNELS);
    assign o_q_push = i_push && !i_q_full && ch_ok;
    assign span     = i_raw_sample - i_dz_low;
    assign den      = i_dz_high - i_dz_low;

    always_comb begin
        o_word.ch         = i_channel;
        o_word.host_ready = i_host_ready;
        o_word.need_div   = 1'b0;
        o_word.mapped     = '0;
        // span * 255 as a shift and subtract
        o_word.num        = {span, {SAMPLE_W{1'b0}}} - NUM_W'(span);
        o_word.den        = den;
        priority if (i_raw_sample <= i_dz_low) begin
            o_word.mapped = '0;
        end else if (i_raw_sample >= i_dz_high) begin
            o_word.mapped = FULL_SCALE;
        end else begin
            o_word.need_div = 1'b1;
        end
    end

endmodule

FILE: rtl/pdh_queue.sv
// Short FIFO of work words between the front and back ends.
// Depends on pdh_pkg.
module pdh_queue import pdh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_word,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_work o_word
);

    t_work               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_word  = r_mem[r_rd];

    function automatic logic [QUEUE_AW-1:0] wrap_inc(input logic [QUEUE_AW-1:0] p);
        if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/pdh_div.sv
// Restoring divider, one quotient bit per cycle, for the deadzone scaling.
// Depends on pdh_pkg.
module pdh_div import pdh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [SAMPLE_W-1:0] i_den,
    output logic                o_done,
    output logic [SAMPLE_W-1:0] o_quo
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [SAMPLE_W-1:0] r_den;
    logic [SAMPLE_W-1:0] r_rem;
    logic [NUM_W-1:0]    r_quo;
    logic [SAMPLE_W:0]   trial;
    logic                fits;

    assign trial  = {r_rem, r_quo[NUM_W-1]};
    assign fits   = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    // quotient never exceeds full scale
    assign o_quo  = r_quo[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= fits ? SAMPLE_W'(trial - {1'b0, r_den}) : trial[SAMPLE_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/pdh_back.sv
// Back end: takes work words, runs the divider, applies hysteresis to the
// per-channel store and holds the outgoing CC word. Depends on pdh_pkg, pdh_div.
module pdh_back import pdh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_work            i_word,
    output logic             o_q_pop,
    input  logic [VAL_W-1:0] i_hysteresis,
    input  logic [VAL_W-1:0] i_cc_base,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [VAL_W-1:0] o_controller_number,
    output logic [VAL_W-1:0] o_control_value
);

    t_back_state         r_state, n_state;
    logic [CH_W-1:0]     r_ch;
    logic                r_host_ready;
    logic [SAMPLE_W-1:0] r_mapped;
    logic [VAL_W-1:0]    r_last [STORE_DEPTH];
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_out_ctrl;
    logic [VAL_W-1:0]    r_out_val;

    logic                div_start;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quo;
    logic                take;
    logic                out_free;
    logic                commit;
    logic [IDX_W-1:0]    idx;
    logic [VAL_W-1:0]    fresh;
    logic [VAL_W-1:0]    prev;
    logic [VAL_W-1:0]    diff;
    logic                upd;

    pdh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_word.num),
        .i_den   (i_word.den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign out_free = !r_out_valid || i_pop;
    assign idx      = r_ch[IDX_W-1:0];
    assign fresh    = r_mapped[SAMPLE_W-1:1];
    assign prev     = r_last[idx];
    assign diff     = (fresh >= prev) ? (fresh - prev) : (prev - fresh);
    assign upd      = ((diff >= i_hysteresis) || (fresh == '0 && prev != '0))
                      && (fresh != prev);

    always_comb begin
        n_state   = r_state;
        take      = 1'b0;
        div_start = 1'b0;
        commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    take = 1'b1;
                    if (i_word.need_div) begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_q_pop = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ch         <= i_word.ch;
            r_host_ready <= i_word.host_ready;
            r_mapped     <= i_word.mapped;
        end else if (r_state == ST_DIV && div_done) begin
            r_mapped <= div_quo;
        end
        if (commit && upd && r_host_ready) begin
            r_out_ctrl <= i_cc_base + VAL_W'(r_ch);
            r_out_val  <= fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_last[k] <= '0;
            end
        end else begin
            if (commit && upd) begin
                r_last[idx] <= fresh;
            end
            if (commit && upd && r_host_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty             = !r_out_valid;
    assign o_controller_number = r_out_ctrl;
    assign o_control_value     = r_out_val;

    a_emit_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && upd && r_host_ready) |=> r_out_valid)
        else $error("update with host ready did not produce a CC word");

    a_store_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && upd) |=> (r_last[$past(idx)] == $past(fresh)))
        else $error("channel store not updated");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !div_start)
        else $error("divider restarted while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_out_valid) |-> i_pop)
        else $error("pending CC word overwritten");

endmodule

FILE: rtl/pot_deadzone_hysteresis_cc_core.sv
// Potentiometer to MIDI control-change core: deadzone mapping, hysteresis
// and a per-channel value store. Depends on pdh_pkg, pdh_front, pdh_queue, pdh_back.
//
// Samples go in through a push/full port and are queued two deep; CC words
// come out through an empty/pop port holding one word. A sample between the
// deadzones is scaled by an iterative divider at one quotient bit per cycle,
// passing through queue pop, 16 divide steps, completion and the hysteresis
// check; a sample in a deadzone goes from queue pop straight to the check. The
// divider sets the sustained rate. Samples for unknown channels are dropped at
// the input. The channel store is cleared by reset. Registers are written
// through the config port and should change only while the core idles.
module pot_deadzone_hysteresis_cc_core import pdh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [CH_W-1:0]      i_channel,
    input  logic [SAMPLE_W-1:0]  i_raw_sample,
    input  logic                 i_host_ready,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [7:0]           o_status_byte,
    output logic [VAL_W-1:0]     o_controller_number,
    output logic [VAL_W-1:0]     o_control_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic [SAMPLE_W-1:0] r_dz_low;
    logic [SAMPLE_W-1:0] r_dz_high;
    logic [VAL_W-1:0]    r_hyst;
    logic [VAL_W-1:0]    r_cc_base;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_work front_word;
    t_work back_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz_low  <= RST_DZ_LOW;
            r_dz_high <= RST_DZ_HIGH;
            r_hyst    <= RST_HYST;
            r_cc_base <= RST_CC_BASE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DZ_LOW:  r_dz_low  <= i_cfg_data;
                CFG_DZ_HIGH: r_dz_high <= i_cfg_data;
                CFG_HYST:    r_hyst    <= i_cfg_data[VAL_W-1:0];
                CFG_CC_BASE: r_cc_base <= i_cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    pdh_front u_front (
        .i_push       (i_push),
        .i_q_full     (q_full),
        .i_channel    (i_channel),
        .i_raw_sample (i_raw_sample),
        .i_host_ready (i_host_ready),
        .i_dz_low     (r_dz_low),
        .i_dz_high    (r_dz_high),
        .o_q_push     (q_push),
        .o_word       (front_word)
    );

    pdh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (front_word),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_word  (back_word)
    );

    pdh_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_empty           (q_empty),
        .i_word              (back_word),
        .o_q_pop             (q_pop),
        .i_hysteresis        (r_hyst),
        .i_cc_base           (r_cc_base),
        .i_pop               (i_pop),
        .o_empty             (o_empty),
        .o_controller_number (o_controller_number),
        .o_control_value     (o_control_value)
    );

    assign o_full        = q_full;
    assign o_status_byte = CC_STATUS;

endmodule
